[rtl/core/tcrs_pkg.sv]
package tcrs_pkg;

	localparam int AREA_W     = 17;
	localparam int TAG_W      = 16;
	localparam int LIMIT_W    = 12;
	localparam int POS_BITS   = 17;

	localparam logic [31:0] AREA_MAGIC = 32'h6472_6148;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;

	localparam logic [1:0] REG_WANTED_TAG = 2'd0;
	localparam logic [1:0] REG_COPY_LIMIT = 2'd1;
	localparam logic [1:0] REG_AREA_SIZE  = 2'd2;
	localparam logic [1:0] REG_BIG_ENDIAN = 2'd3;

	typedef struct packed {
		logic [7:0] area_byte;
		logic       area_start;
	} area_req_t;

	typedef struct packed {
		logic [7:0]         payload_byte;
		logic               byte_valid;
		logic               search_done;
		logic [1:0]         search_status;
		logic [LIMIT_W-1:0] copied_count;
	} result_t;

	typedef struct packed {
		logic [TAG_W-1:0]   wanted_tag;
		logic [LIMIT_W-1:0] copy_limit;
		logic [AREA_W-1:0]  area_size;
		logic               big_endian_words;
	} cfg_t;

endpackage

[rtl/core/tcrs_scan.sv]
module tcrs_scan #(
	parameter int PositionBits = tcrs_pkg::POS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tcrs_pkg::area_req_t item,
	input  tcrs_pkg::cfg_t      cfg,
	output logic                has_result,
	output tcrs_pkg::result_t   res
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_MAGIC  = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_SKIP   = 3'd3;
	localparam logic [2:0] PH_COPY   = 3'd4;

	localparam int CmpW = (PositionBits > tcrs_pkg::AREA_W) ? PositionBits : tcrs_pkg::AREA_W;
	localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};

	logic [PositionBits-1:0]     pos_q, pos_e, pos_d;
	logic [2:0]                  phase_q, phase_e, phase_d;
	logic [31:0]                 word_q, word_e, word_d, word_n;
	logic [1:0]                  hcnt_q, hcnt_e, hcnt_d;
	logic [15:0]                 rem_q, rem_e, rem_d, rem_dec;
	logic [tcrs_pkg::LIMIT_W-1:0] copied_q, copied_e, copied_d, copied_inc;

	logic        full;
	logic        hdr_outside;
	logic [15:0] tag, len, limit_x, amt;

	always_comb begin
		if (item.area_start) begin
			pos_e    = '0;
			phase_e  = PH_MAGIC;
			word_e   = '0;
			hcnt_e   = '0;
			rem_e    = '0;
			copied_e = '0;
		end else begin
			pos_e    = pos_q;
			phase_e  = phase_q;
			word_e   = word_q;
			hcnt_e   = hcnt_q;
			rem_e    = rem_q;
			copied_e = copied_q;
		end

		pos_d  = (pos_e != PosMax) ? pos_e + 1'b1 : pos_e;
		word_n = cfg.big_endian_words ? {word_e[23:0], item.area_byte}
		                              : {item.area_byte, word_e[31:8]};
		full   = (hcnt_e == 2'd3);
		hdr_outside = CmpW'(pos_d) >= CmpW'(cfg.area_size);

		tag     = word_n[15:0];
		len     = word_n[31:16];
		limit_x = 16'(cfg.copy_limit);
		amt     = (len < limit_x) ? len : limit_x;
		rem_dec = (rem_e != 16'd0) ? rem_e - 1'b1 : rem_e;
		copied_inc = copied_e + 1'b1;

		phase_d  = phase_e;
		word_d   = word_n;
		hcnt_d   = hcnt_e + 1'b1;
		rem_d    = rem_e;
		copied_d = copied_e;

		has_result        = 1'b0;
		res.payload_byte  = '0;
		res.byte_valid    = 1'b0;
		res.search_done   = 1'b1;
		res.search_status = tcrs_pkg::ST_NOT_FOUND;
		res.copied_count  = copied_e;

		case (phase_e)
			PH_MAGIC: begin
				if (full) begin
					if (word_n != tcrs_pkg::AREA_MAGIC) begin
						has_result        = 1'b1;
						res.search_status = tcrs_pkg::ST_BAD_MAGIC;
						phase_d           = PH_IDLE;
					end else if (hdr_outside) begin
						has_result = 1'b1;
						phase_d    = PH_IDLE;
					end else begin
						phase_d = PH_HEADER;
						word_d  = '0;
					end
				end
			end
			PH_HEADER: begin
				if (full) begin
					if (len == 16'd0 || 17'(len) > cfg.area_size || tag == 16'd0) begin
						has_result = 1'b1;
						phase_d    = PH_IDLE;
					end else if (tag == cfg.wanted_tag) begin
						if (amt == 16'd0) begin
							has_result        = 1'b1;
							res.search_status = tcrs_pkg::ST_FOUND;
							phase_d           = PH_IDLE;
						end else begin
							rem_d    = amt;
							copied_d = '0;
							phase_d  = PH_COPY;
						end
					end else begin
						rem_d   = len;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				rem_d = rem_dec;
				if (rem_dec == 16'd0) begin
					if (hdr_outside) begin
						has_result = 1'b1;
						phase_d    = PH_IDLE;
					end else begin
						phase_d = PH_HEADER;
						word_d  = '0;
						hcnt_d  = '0;
					end
				end
			end
			PH_COPY: begin
				rem_d             = rem_dec;
				copied_d          = copied_inc;
				has_result        = 1'b1;
				res.payload_byte  = item.area_byte;
				res.byte_valid    = 1'b1;
				res.search_done   = (rem_dec == 16'd0);
				res.search_status = tcrs_pkg::ST_FOUND;
				res.copied_count  = copied_inc;
				if (rem_dec == 16'd0) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_IDLE;
			word_q   <= '0;
			hcnt_q   <= '0;
			rem_q    <= '0;
			copied_q <= '0;
		end else if (step) begin
			pos_q    <= pos_d;
			phase_q  <= phase_d;
			word_q   <= word_d;
			hcnt_q   <= hcnt_d;
			rem_q    <= rem_d;
			copied_q <= copied_d;
		end
	end

endmodule

[rtl/core/tlv_config_record_search_core.sv]
// channel  | handshake                   | payload
// area     | area_valid / area_ready     | area_req (area_byte, area_start)
// result   | result_valid / result_ready | result (byte, flags, status, count)
// config   | cfg_we, no wait             | cfg_index, cfg_data
//
// One area byte per cycle when the result side keeps up; a result passes through
// the input register, then the result register, before it is presented.
// The scan state is updated only when the registered request moves on, which
// stalls when it yields a result and the result register is still held.
// Reset clears scan state, valid flags and configuration to its defaults.
module tlv_config_record_search_core #(
	parameter int PositionBits = tcrs_pkg::POS_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           area_valid,
	output logic                           area_ready,
	input  tcrs_pkg::area_req_t            area_req,
	output logic                           result_valid,
	input  logic                           result_ready,
	output tcrs_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [tcrs_pkg::AREA_W-1:0]    cfg_data
);

	tcrs_pkg::cfg_t      cfg_q;
	tcrs_pkg::area_req_t req_s1;
	logic                valid_s1;
	tcrs_pkg::result_t   res_s2, res_c;
	logic                valid_s2;
	logic                has_result;
	logic                out_free;
	logic                step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_tag       <= 16'd1;
			cfg_q.copy_limit       <= 12'd4;
			cfg_q.area_size        <= '0;
			cfg_q.big_endian_words <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				tcrs_pkg::REG_WANTED_TAG: cfg_q.wanted_tag <= cfg_data[tcrs_pkg::TAG_W-1:0];
				tcrs_pkg::REG_COPY_LIMIT: cfg_q.copy_limit <= cfg_data[tcrs_pkg::LIMIT_W-1:0];
				tcrs_pkg::REG_AREA_SIZE:  cfg_q.area_size  <= cfg_data;
				tcrs_pkg::REG_BIG_ENDIAN: cfg_q.big_endian_words <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free   = !valid_s2 || result_ready;
	assign step       = valid_s1 && (!has_result || out_free);
	assign area_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (area_ready) begin
			valid_s1 <= area_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (area_ready && area_valid) begin
			req_s1 <= area_req;
		end
	end

	tcrs_scan #(
		.PositionBits(PositionBits)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (req_s1),
		.cfg       (cfg_q),
		.has_result(has_result),
		.res       (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && has_result) begin
			res_s2 <= res_c;
		end
	end

	assign result_valid = valid_s2;
	assign result       = res_s2;

	a_byte_is_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid |-> result.search_status == tcrs_pkg::ST_FOUND)
		else $error("copied byte without found status");

	a_open_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.search_done |-> result.byte_valid)
		else $error("non-final result without a byte");

	a_bad_magic_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.search_status == tcrs_pkg::ST_BAD_MAGIC
		|-> result.copied_count == '0 && !result.byte_valid)
		else $error("bad magic result carries data");

	a_byte_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid |-> result.copied_count != '0)
		else $error("copied byte with zero count");

endmodule

[dv/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET   = 1450;
	localparam int WATCHDOG_MAX  = 2000;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_MAGIC,
		SCAN_HEADER,
		SCAN_SKIP,
		SCAN_COPY
	} scan_e;

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        area_valid   = 1'b0;
	logic                        area_ready;
	tcrs_pkg::area_req_t         area_req     = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	tcrs_pkg::result_t           result;
	logic                        cfg_we       = 1'b0;
	logic [1:0]                  cfg_index    = tcrs_pkg::REG_WANTED_TAG;
	logic [tcrs_pkg::AREA_W-1:0] cfg_data     = '0;

	tlv_config_record_search_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.area_valid   (area_valid),
		.area_ready   (area_ready),
		.area_req     (area_req),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// search predictor state
	tcrs_pkg::cfg_t                 model_cfg = '{16'd1, 12'd4, 17'd0, 1'b1};
	scan_e                          scan_ph   = SCAN_IDLE;
	logic [tcrs_pkg::POS_BITS-1:0]  scan_pos  = '0;
	logic [31:0]                    word_acc  = '0;
	logic [1:0]                     word_cnt  = '0;
	logic [15:0]                    left_cnt  = '0;
	logic [tcrs_pkg::LIMIT_W-1:0]   copy_cnt  = '0;

	tcrs_pkg::result_t pending_results[$];
	logic [7:0]  area_img[$];
	int          mismatches   = 0;
	int          taken_total  = 0;
	int          burst_left   = 0;
	int          idle_cycles  = 0;
	bit          valid_up     = 1'b0;
	bit          hold_ready   = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic bit take_byte(input logic [7:0] b);
		word_acc = model_cfg.big_endian_words ? {word_acc[23:0], b} : {b, word_acc[31:8]};
		if (word_cnt == 2'd3) begin
			word_cnt = 2'd0;
			return 1'b1;
		end
		word_cnt++;
		return 1'b0;
	endfunction

	function automatic bit close_search(input logic [1:0] status,
			output tcrs_pkg::result_t r);
		scan_ph = SCAN_IDLE;
		r = '0;
		r.search_done = 1'b1;
		r.search_status = status;
		r.copied_count = copy_cnt;
		return 1'b1;
	endfunction

	function automatic bit open_header(output tcrs_pkg::result_t r);
		r = '0;
		if (scan_pos >= model_cfg.area_size)
			return close_search(tcrs_pkg::ST_NOT_FOUND, r);
		scan_ph = SCAN_HEADER;
		word_acc = '0;
		word_cnt = '0;
		return 1'b0;
	endfunction

	function automatic bit predict_area(input logic [7:0] b, input logic s,
			output tcrs_pkg::result_t r);
		logic [15:0] tag;
		logic [15:0] len;
		logic [15:0] amt;
		r = '0;
		if (s) begin
			scan_pos = '0;
			scan_ph = SCAN_MAGIC;
			word_acc = '0;
			word_cnt = '0;
			left_cnt = '0;
			copy_cnt = '0;
		end else if (scan_ph == SCAN_IDLE) begin
			return 1'b0;
		end
		if (scan_pos != '1)
			scan_pos++;
		case (scan_ph)
			SCAN_MAGIC: begin
				if (!take_byte(b))
					return 1'b0;
				if (word_acc != tcrs_pkg::AREA_MAGIC)
					return close_search(tcrs_pkg::ST_BAD_MAGIC, r);
				return open_header(r);
			end
			SCAN_HEADER: begin
				if (!take_byte(b))
					return 1'b0;
				tag = word_acc[15:0];
				len = word_acc[31:16];
				if (len == '0 || len > model_cfg.area_size || tag == '0)
					return close_search(tcrs_pkg::ST_NOT_FOUND, r);
				if (tag == model_cfg.wanted_tag) begin
					amt = (len < {4'd0, model_cfg.copy_limit}) ? len : {4'd0, model_cfg.copy_limit};
					if (amt == '0)
						return close_search(tcrs_pkg::ST_FOUND, r);
					left_cnt = amt;
					copy_cnt = '0;
					scan_ph = SCAN_COPY;
					return 1'b0;
				end
				left_cnt = len;
				scan_ph = SCAN_SKIP;
				return 1'b0;
			end
			SCAN_SKIP: begin
				if (left_cnt != '0)
					left_cnt--;
				if (left_cnt != '0)
					return 1'b0;
				return open_header(r);
			end
			default: begin
				if (left_cnt != '0)
					left_cnt--;
				copy_cnt++;
				r.payload_byte = b;
				r.byte_valid = 1'b1;
				r.search_status = tcrs_pkg::ST_FOUND;
				r.copied_count = copy_cnt;
				if (left_cnt == '0) begin
					scan_ph = SCAN_IDLE;
					r.search_done = 1'b1;
				end
				return 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic send_req(input logic [7:0] b, input logic s);
		tcrs_pkg::result_t r;
		if (burst_left == 0)
			burst_left = $urandom_range(1, 48);
		area_valid <= 1'b1;
		area_req <= '{area_byte: b, area_start: s};
		valid_up = 1'b1;
		do @(posedge clk); while (!area_ready);
		taken_total++;
		if (predict_area(b, s, r))
			pending_results.push_back(r);
		burst_left--;
		if (burst_left == 0) begin
			area_valid <= 1'b0;
			valid_up = 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_quiet();
		if (valid_up) begin
			area_valid <= 1'b0;
			valid_up = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// unused upper data bits are randomized; registers keep only their width
	task automatic write_config(input logic [15:0] tag, input logic [11:0] lim,
			input logic [16:0] size, input logic be);
		cfg_we <= 1'b1;
		cfg_index <= tcrs_pkg::REG_WANTED_TAG;
		cfg_data <= {1'($urandom()), tag};
		@(posedge clk);
		cfg_index <= tcrs_pkg::REG_COPY_LIMIT;
		cfg_data <= {5'($urandom()), lim};
		@(posedge clk);
		cfg_index <= tcrs_pkg::REG_AREA_SIZE;
		cfg_data <= size;
		@(posedge clk);
		cfg_index <= tcrs_pkg::REG_BIG_ENDIAN;
		cfg_data <= {16'($urandom()), be};
		@(posedge clk);
		cfg_we <= 1'b0;
		model_cfg = '{tag, lim, size, be};
	endtask

	function automatic void add_word(input logic [31:0] w);
		if (model_cfg.big_endian_words) begin
			area_img.push_back(w[31:24]);
			area_img.push_back(w[23:16]);
			area_img.push_back(w[15:8]);
			area_img.push_back(w[7:0]);
		end else begin
			area_img.push_back(w[7:0]);
			area_img.push_back(w[15:8]);
			area_img.push_back(w[23:16]);
			area_img.push_back(w[31:24]);
		end
	endfunction

	function automatic void add_bytes(input int n);
		repeat (n) area_img.push_back(8'($urandom()));
	endfunction

	task automatic send_image();
		foreach (area_img[i])
			send_req(area_img[i], i == 0);
	endtask

	// reset values: area size 0 ends every search right after the magic word
	task automatic test_idle_and_defaults();
		send_req(8'h00, 1'b0);
		send_req(8'hff, 1'b0);
		area_img.delete();
		add_word(tcrs_pkg::AREA_MAGIC);
		send_image();
		send_req(8'h5a, 1'b0);
		wait_quiet();
	endtask

	task automatic test_directed();
		write_config(16'hffff, 12'd3, 17'd24, 1'b1);
		area_img.delete();
		add_word(tcrs_pkg::AREA_MAGIC ^ 32'h0000_0100);
		send_image();
		// restart partway through the magic word
		area_img.delete();
		add_word(tcrs_pkg::AREA_MAGIC);
		send_req(area_img[0], 1'b1);
		send_req(area_img[1], 1'b0);
		add_word({16'd5, 16'hffff});
		area_img.push_back(8'hff);
		area_img.push_back(8'h00);
		area_img.push_back(8'ha5);
		send_image();
		wait_quiet();
		// little endian, skip a record, then zero copy limit
		write_config(16'd2, 12'd0, 17'd16, 1'b0);
		area_img.delete();
		add_word(tcrs_pkg::AREA_MAGIC);
		add_word({16'd2, 16'd7});
		add_bytes(2);
		add_word({16'd1, 16'd2});
		send_image();
		wait_quiet();
	endtask

	// receiver stalls long enough for the block to back up onto its input
	task automatic test_backpressure();
		write_config(16'd5, 12'd64, 17'd200, 1'b1);
		area_img.delete();
		add_word(tcrs_pkg::AREA_MAGIC);
		add_word({16'd64, 16'd5});
		add_bytes(64);
		burst_left = 1000;
		hold_ready = 1'b1;
		send_image();
		burst_left = 0;
		wait_quiet();
	endtask

	task automatic test_random();
		logic [15:0] tag;
		logic [11:0] lim;
		logic [16:0] size;
		logic [31:0] magic;
		logic [15:0] rtag;
		logic [15:0] len;
		int pick;
		int keep;
		while (taken_total < ITEM_TARGET) begin
			wait_quiet();
			pick = $urandom_range(0, 9);
			tag = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hffff : 16'($urandom_range(1, 65535));
			pick = $urandom_range(0, 9);
			lim = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hfff :
				(pick < 7) ? 12'($urandom_range(1, 8)) : 12'($urandom());
			pick = $urandom_range(0, 19);
			size = (pick == 0) ? 17'd0 : (pick < 3) ? 17'h1ffff : (pick == 3) ? 17'd4 :
				(pick < 16) ? 17'($urandom_range(5, 80)) : 17'($urandom());
			write_config(tag, lim, size, 1'($urandom()));
			repeat ($urandom_range(3, 10)) begin
				if (taken_total >= ITEM_TARGET)
					break;
				area_img.delete();
				magic = tcrs_pkg::AREA_MAGIC;
				pick = $urandom_range(0, 19);
				if (pick == 0)
					magic = $urandom();
				else if (pick == 1)
					magic = tcrs_pkg::AREA_MAGIC ^ (32'd1 << $urandom_range(0, 31));
				add_word(magic);
				repeat ($urandom_range(0, 4)) begin
					pick = $urandom_range(0, 99);
					if (pick < 40)
						rtag = model_cfg.wanted_tag;
					else if (pick < 48)
						rtag = '0;
					else if (pick < 56)
						rtag = 16'hffff;
					else
						rtag = 16'($urandom_range(1, 65535));
					pick = $urandom_range(0, 99);
					if (pick < 50)
						len = 16'($urandom_range(1, 8));
					else if (pick < 70)
						len = 16'($urandom_range(9, 40));
					else if (pick < 78)
						len = '0;
					else if (pick < 86)
						len = 16'hffff;
					else if (pick < 94)
						len = 16'(model_cfg.area_size + 17'($urandom_range(0, 1)));
					else
						len = 16'($urandom());
					add_word({len, rtag});
					add_bytes((len > 16'd40) ? 40 : int'(len));
				end
				// truncated image: the next area restarts the search
				if ($urandom_range(0, 7) == 0) begin
					keep = $urandom_range(1, area_img.size());
					while (area_img.size() > keep)
						void'(area_img.pop_back());
				end
				send_image();
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 6)) send_req(8'($urandom()), 1'b0);
			end
		end
	endtask

	initial begin : rx_stall
		int seg;
		int mode;
		int k;
		k = 0;
		forever begin
			if (hold_ready) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_ready = 1'b0;
			end else begin
				seg = $urandom_range(4, 40);
				mode = $urandom_range(0, 3);
				repeat (seg) begin
					k++;
					case (mode)
						0: result_ready <= 1'b1;
						1: result_ready <= 1'($urandom());
						2: result_ready <= ($urandom_range(0, 5) == 0);
						default: result_ready <= (k % 4 != 3);
					endcase
					@(posedge clk);
					if (hold_ready)
						break;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		tcrs_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", int'(result), 0);
			end else begin
				want = pending_results.pop_front();
				if (result.payload_byte != want.payload_byte)
					report_mismatch("payload_byte", result.payload_byte, want.payload_byte);
				if (result.byte_valid != want.byte_valid)
					report_mismatch("byte_valid", result.byte_valid, want.byte_valid);
				if (result.search_done != want.search_done)
					report_mismatch("search_done", result.search_done, want.search_done);
				if (result.search_status != want.search_status)
					report_mismatch("search_status", result.search_status, want.search_status);
				if (result.copied_count != want.copied_count)
					report_mismatch("copied_count", result.copied_count, want.copied_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((area_valid && area_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_defaults();
		test_directed();
		test_backpressure();
		test_random();
		wait_quiet();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
